### rtl/core/sed_pkg.sv
// shared types, character codes and decode functions of the string escape decoder
`timescale 1ns / 1ps
`default_nettype none

package sed_pkg;

  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_X         = 8'h78;
  localparam logic [7:0] CHAR_QUOTE     = 8'h22;
  localparam logic [7:0] CHAR_ZERO      = 8'h30;
  localparam logic [7:0] CHAR_N         = 8'h6E;
  localparam logic [7:0] CHAR_T         = 8'h74;
  localparam logic [7:0] CHAR_R         = 8'h72;
  localparam logic [7:0] CHAR_A         = 8'h61;
  localparam logic [7:0] CHAR_B         = 8'h62;
  localparam logic [7:0] CHAR_F         = 8'h66;
  localparam logic [7:0] CHAR_V         = 8'h76;

  localparam logic [1:0] WORDS_ONE   = 2'd1;
  localparam logic [1:0] WORDS_TWO   = 2'd2;
  localparam logic [1:0] WORDS_THREE = 2'd3;
  localparam logic [1:0] WORDS_NONE  = 2'd0;

  // one decoded group of words from one input byte
  typedef struct packed {
    logic [1:0]      count;
    logic [2:0][7:0] data;
    logic            last;
    logic            bad;
  } cmd_t;

  // {valid, digit}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

  // {hit, decoded byte}
  function automatic logic [8:0] simple_escape(input logic [7:0] c);
    logic [8:0] r;
    case (c)
      CHAR_N:         r = {1'b1, 8'd10};
      CHAR_T:         r = {1'b1, 8'd9};
      CHAR_R:         r = {1'b1, 8'd13};
      CHAR_BACKSLASH: r = {1'b1, CHAR_BACKSLASH};
      CHAR_QUOTE:     r = {1'b1, 8'd34};
      CHAR_ZERO:      r = {1'b1, 8'd0};
      CHAR_A:         r = {1'b1, 8'd7};
      CHAR_B:         r = {1'b1, 8'd8};
      CHAR_F:         r = {1'b1, 8'd12};
      CHAR_V:         r = {1'b1, 8'd11};
      default:        r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/core/string_escape_decoder_unit.sv
// Decodes C string literal bytes: a byte-wide stream of raw characters with
// the string end marked by last_in. Each accepted input word yields zero to
// three decoded output words on the output channel; last_out marks the final
// decoded word of a string and bad_hex flags a hex escape with no valid
// leading digit (that word carries 0).
// With an empty queue the first word caused by an input is written into the
// queue by the accepting edge and then loaded into the output register once
// that register is free.
// Throughput: one input word per cycle while the queue has room; the back
// end emits one output word per cycle while out_ready is high, so an input
// that expands to two or three words (unknown escape, string ending inside
// a hex escape) emits its words in turn, absorbed by the QUEUE_DEPTH-entry
// group queue; in_ready drops only when it is full. A stalled receiver holds
// the output register and back-pressures the input once the queue fills.
// Reset (synchronous): decoder returns to plain text, queue is emptied and
// out_valid clears.
`timescale 1ns / 1ps
`default_nettype none

module string_escape_decoder_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] char_in,
  input  wire logic       last_in,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      char_out,
  output logic            last_out,
  output logic            bad_hex
);

  sed_pkg::cmd_t cmd, head;
  logic          cmd_push, head_valid, pop, accept;

  assign accept = in_valid && in_ready;

  sed_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .char_in  (char_in),
    .last_in  (last_in),
    .cmd      (cmd),
    .cmd_push (cmd_push)
  );

  sed_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (cmd_push),
    .push_cmd   (cmd),
    .ready      (in_ready),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  sed_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .char_out   (char_out),
    .last_out   (last_out),
    .bad_hex    (bad_hex)
  );

endmodule

`default_nettype wire

### rtl/core/sed_front.sv
// front end: escape state machine that turns each input byte into a word group
`timescale 1ns / 1ps
`default_nettype none

module sed_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          accept,
  input  wire logic [7:0]    char_in,
  input  wire logic          last_in,
  output sed_pkg::cmd_t      cmd,
  output logic               cmd_push
);

  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_ESC   = 2'd1,
    MODE_HEX1  = 2'd2,
    MODE_HEX2  = 2'd3
  } mode_t;

  mode_t      mode, mode_next;
  logic [7:0] first_hex_byte, first_hex_byte_next;
  logic [8:0] esc;
  logic [4:0] d1, d2;

  always_comb begin
    esc = sed_pkg::simple_escape(char_in);
    d1  = sed_pkg::hex_digit(first_hex_byte);
    d2  = sed_pkg::hex_digit(char_in);
    mode_next           = mode;
    first_hex_byte_next = first_hex_byte;
    cmd.count = sed_pkg::WORDS_NONE;
    cmd.data  = '0;
    cmd.last  = last_in;
    cmd.bad   = 1'b0;
    case (mode)
      MODE_PLAIN: begin
        if (char_in == sed_pkg::CHAR_BACKSLASH && !last_in) begin
          mode_next = MODE_ESC;
        end else begin
          cmd.count   = sed_pkg::WORDS_ONE;
          cmd.data[0] = char_in;
        end
      end
      MODE_ESC: begin
        mode_next = MODE_PLAIN;
        if (esc[8]) begin
          cmd.count   = sed_pkg::WORDS_ONE;
          cmd.data[0] = esc[7:0];
        end else if (char_in == sed_pkg::CHAR_X && !last_in) begin
          mode_next = MODE_HEX1;
        end else begin
          cmd.count   = sed_pkg::WORDS_TWO;
          cmd.data[0] = sed_pkg::CHAR_BACKSLASH;
          cmd.data[1] = char_in;
        end
      end
      MODE_HEX1: begin
        if (last_in) begin
          // string ended inside the escape: pass everything through
          mode_next   = MODE_PLAIN;
          cmd.count   = sed_pkg::WORDS_THREE;
          cmd.data[0] = sed_pkg::CHAR_BACKSLASH;
          cmd.data[1] = sed_pkg::CHAR_X;
          cmd.data[2] = char_in;
        end else begin
          first_hex_byte_next = char_in;
          mode_next           = MODE_HEX2;
        end
      end
      default: begin
        mode_next           = MODE_PLAIN;
        first_hex_byte_next = 8'd0;
        cmd.count           = sed_pkg::WORDS_ONE;
        if (!d1[4]) begin
          cmd.bad = 1'b1;
        end else if (!d2[4]) begin
          cmd.data[0] = {4'd0, d1[3:0]};
        end else begin
          cmd.data[0] = {d1[3:0], d2[3:0]};
        end
      end
    endcase
    if (last_in) begin
      mode_next           = MODE_PLAIN;
      first_hex_byte_next = 8'd0;
    end
    cmd_push = accept && (cmd.count != sed_pkg::WORDS_NONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_PLAIN;
      first_hex_byte <= 8'd0;
    end else if (accept) begin
      mode           <= mode_next;
      first_hex_byte <= first_hex_byte_next;
    end
  end

`ifndef SYNTHESIS
  // a string end always leaves the decoder in plain text
  a_last_resets_mode: assert property (@(posedge clk) disable iff (rst)
    accept && last_in |=> mode == MODE_PLAIN)
    else $error("escape mode not cleared after string end");
  // every string end produces at least one word
  a_last_pushes: assert property (@(posedge clk) disable iff (rst)
    accept && last_in |-> cmd_push)
    else $error("string end produced no word");
`endif

endmodule

`default_nettype wire

### rtl/core/sed_queue.sv
// short queue of word groups between the front and back ends
`timescale 1ns / 1ps
`default_nettype none

module sed_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire sed_pkg::cmd_t push_cmd,
  output logic               ready,
  input  wire logic          pop,
  output sed_pkg::cmd_t      head,
  output logic               head_valid
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  sed_pkg::cmd_t     slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;

  assign ready      = count != CNT_W'(DEPTH);
  assign head_valid = count != '0;
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> ready || pop)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("queue read while empty");
`endif

endmodule

`default_nettype wire

### rtl/core/sed_back.sv
// back end: steps through each word group and drives the output register
`timescale 1ns / 1ps
`default_nettype none

module sed_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire sed_pkg::cmd_t head,
  input  wire logic          head_valid,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [7:0]         char_out,
  output logic               last_out,
  output logic               bad_hex
);

  logic [1:0] idx;
  logic       load, final_word;
  logic [7:0] sel_byte;

  assign load       = head_valid && (!out_valid || out_ready);
  assign final_word = (idx == head.count - 2'd1);
  assign pop        = load && final_word;

  always_comb begin
    case (idx)
      2'd0:    sel_byte = head.data[0];
      2'd1:    sel_byte = head.data[1];
      default: sel_byte = head.data[2];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= final_word ? 2'd0 : idx + 2'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      char_out <= sel_byte;
      last_out <= head.last && final_word;
      bad_hex  <= head.bad;
    end
  end

`ifndef SYNTHESIS
  // word index stays inside the group at the head
  a_idx_in_group: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> idx < head.count)
    else $error("word index past end of group");
`endif

endmodule

`default_nettype wire

### sim/string_escape_decoder_checker.sv
// checker for the string escape decoder: predicts decoded words and compares them
`timescale 1ns / 1ps

module string_escape_decoder_checker (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic       in_ready,
  input  wire logic [7:0] char_in,
  input  wire logic       last_in,
  input  wire logic       out_valid,
  input  wire logic       out_ready,
  input  wire logic [7:0] char_out,
  input  wire logic       last_out,
  input  wire logic       bad_hex,
  output int              fail_count,
  output int              expected_count
);

  typedef enum logic [1:0] {
    SCAN_TEXT,
    SCAN_ESCAPE,
    SCAN_HEX_FIRST,
    SCAN_HEX_SECOND
  } scan_state_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       bad;
  } decoded_word_t;

  localparam int NOT_HEX    = 16;
  localparam int NOT_SIMPLE = 256;

  scan_state_t     scan_state = SCAN_TEXT;
  logic [7:0]      held_digit = 8'd0;
  decoded_word_t   decoded_q[$];
  int              mismatches = 0;

  assign fail_count = mismatches;

  function automatic int digit_of(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
    return NOT_HEX;
  endfunction

  function automatic int escape_byte(input logic [7:0] c);
    case (c)
      sed_pkg::CHAR_N:         return 10;
      sed_pkg::CHAR_T:         return 9;
      sed_pkg::CHAR_R:         return 13;
      sed_pkg::CHAR_BACKSLASH: return 'h5C;
      sed_pkg::CHAR_QUOTE:     return 34;
      sed_pkg::CHAR_ZERO:      return 0;
      sed_pkg::CHAR_A:         return 7;
      sed_pkg::CHAR_B:         return 8;
      sed_pkg::CHAR_F:         return 12;
      sed_pkg::CHAR_V:         return 11;
      default:                 return NOT_SIMPLE;
    endcase
  endfunction

  task automatic queue_word(input logic [7:0] c, input logic bad);
    decoded_word_t w;
    w.ch   = c;
    w.last = 1'b0;
    w.bad  = bad;
    decoded_q.insert(decoded_q.size(), w);
  endtask

  task automatic decode_step(input logic [7:0] c, input logic is_last);
    int            hi;
    int            lo;
    int            esc;
    int            size_at_start;
    size_at_start = decoded_q.size();
    case (scan_state)
      SCAN_TEXT: begin
        if (c == sed_pkg::CHAR_BACKSLASH && !is_last) scan_state = SCAN_ESCAPE;
        else queue_word(c, 1'b0);
      end
      SCAN_ESCAPE: begin
        esc = escape_byte(c);
        if (esc != NOT_SIMPLE) begin
          queue_word(8'(esc), 1'b0);
          scan_state = SCAN_TEXT;
        end else if (c == sed_pkg::CHAR_X && !is_last) begin
          scan_state = SCAN_HEX_FIRST;
        end else begin
          queue_word(sed_pkg::CHAR_BACKSLASH, 1'b0);
          queue_word(c, 1'b0);
          scan_state = SCAN_TEXT;
        end
      end
      SCAN_HEX_FIRST: begin
        // string ends inside the escape: everything held comes out raw
        if (is_last) begin
          queue_word(sed_pkg::CHAR_BACKSLASH, 1'b0);
          queue_word(sed_pkg::CHAR_X, 1'b0);
          queue_word(c, 1'b0);
          scan_state = SCAN_TEXT;
        end else begin
          held_digit = c;
          scan_state = SCAN_HEX_SECOND;
        end
      end
      default: begin
        hi = digit_of(held_digit);
        lo = digit_of(c);
        if (hi == NOT_HEX) queue_word(8'd0, 1'b1);
        else if (lo == NOT_HEX) queue_word(8'(hi), 1'b0);
        else queue_word(8'(hi * 16 + lo), 1'b0);
        scan_state = SCAN_TEXT;
        held_digit = 8'd0;
      end
    endcase
    if (is_last) begin
      if (decoded_q.size() > size_at_start) begin
        decoded_q[decoded_q.size() - 1].last = 1'b1;
      end
      scan_state = SCAN_TEXT;
      held_digit = 8'd0;
    end
  endtask

  always @(posedge clk) begin
    decoded_word_t want;
    if (rst) begin
      scan_state = SCAN_TEXT;
      held_digit = 8'd0;
      decoded_q.delete();
      expected_count <= 0;
    end else begin
      if (in_valid && in_ready) decode_step(char_in, last_in);
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual char %02h last %b bad %b",
                   $time, char_out, last_out, bad_hex);
          mismatches++;
        end else begin
          want = decoded_q.pop_front();
          if (char_out !== want.ch) begin
            $display("%0t: char_out expected %02h actual %02h", $time, want.ch, char_out);
            mismatches++;
          end
          if (last_out !== want.last) begin
            $display("%0t: last_out expected %b actual %b", $time, want.last, last_out);
            mismatches++;
          end
          if (bad_hex !== want.bad) begin
            $display("%0t: bad_hex expected %b actual %b", $time, want.bad, bad_hex);
            mismatches++;
          end
        end
      end
      expected_count <= decoded_q.size();
    end
  end

endmodule

### sim/string_escape_decoder_unit_test.sv
// top of the string escape decoder testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module string_escape_decoder_unit_test;

  localparam int RANDOM_WORDS = 230;
  localparam int HOLD_AT      = 70;   // receiver starts its long hold-off here
  localparam int DRAIN_AT     = 140;  // sender waits for the output to drain here
  localparam int QUIET_AT     = 190;  // no idling from here on
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_LIMIT  = 50000;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic [7:0] char_in   = 8'd0;
  logic       last_in   = 1'b0;
  logic       out_ready = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic [7:0] char_out;
  logic       last_out;
  logic       bad_hex;
  int         fail_count;
  int         expected_count;

  logic [7:0] text_bytes[$];
  int         words_sent = 0;
  bit         quiet      = 1'b0;
  bit         hold_req   = 1'b0;
  bit         drained    = 1'b0;

  string_escape_decoder_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .char_in  (char_in),
    .last_in  (last_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .char_out (char_out),
    .last_out (last_out),
    .bad_hex  (bad_hex)
  );

  string_escape_decoder_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .char_in       (char_in),
    .last_in       (last_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .char_out      (char_out),
    .last_out      (last_out),
    .bad_hex       (bad_hex),
    .fail_count    (fail_count),
    .expected_count(expected_count)
  );

  always #5 clk = ~clk;

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  function automatic logic [7:0] pick_hex_digit();
    int d;
    d = $urandom_range(0, 21);
    if (d < 10) return 8'(8'h30 + d);
    if (d < 16) return 8'(8'h61 + d - 10);
    return 8'(8'h41 + d - 16);
  endfunction

  function automatic logic [7:0] pick_non_hex();
    case ($urandom_range(0, 6))
      0:       return 8'h20;  // space
      1:       return 8'h2B;  // plus
      2:       return 8'h2D;  // minus
      3:       return 8'h00;
      4:       return 8'hFF;
      5:       return 8'h09;  // tab
      default: return 8'($urandom_range(8'h67, 8'h7A));  // g..z
    endcase
  endfunction

  function automatic logic [7:0] pick_simple();
    case ($urandom_range(0, 9))
      0:       return sed_pkg::CHAR_N;
      1:       return sed_pkg::CHAR_T;
      2:       return sed_pkg::CHAR_R;
      3:       return sed_pkg::CHAR_BACKSLASH;
      4:       return sed_pkg::CHAR_QUOTE;
      5:       return sed_pkg::CHAR_ZERO;
      6:       return sed_pkg::CHAR_A;
      7:       return sed_pkg::CHAR_B;
      8:       return sed_pkg::CHAR_F;
      default: return sed_pkg::CHAR_V;
    endcase
  endfunction

  task automatic add_byte(input logic [7:0] b);
    text_bytes.insert(text_bytes.size(), b);
  endtask

  // sends text_bytes as one string, last on the final word
  task automatic send_text();
    for (int i = 0; i < text_bytes.size(); i++) begin
      in_valid <= 1'b1;
      char_in  <= text_bytes[i];
      last_in  <= (i == text_bytes.size() - 1);
      do @(posedge clk); while (!in_ready);
      words_sent++;
      if (words_sent == HOLD_AT) hold_req = 1'b1;
      if (words_sent >= QUIET_AT) quiet = 1'b1;
      if (!drained && words_sent >= DRAIN_AT && i == text_bytes.size() - 1) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_count != 0) @(posedge clk);
        drained = 1'b1;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
    end
  endtask

  task automatic build_random_text();
    int tokens;
    int cut;
    text_bytes.delete();
    tokens = $urandom_range(1, 5);
    repeat (tokens) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: add_byte(8'($urandom_range(0, 255)));
        4, 5: begin
          add_byte(sed_pkg::CHAR_BACKSLASH);
          add_byte(pick_simple());
        end
        6: begin
          add_byte(sed_pkg::CHAR_BACKSLASH);
          add_byte(8'($urandom_range(0, 255)));
        end
        default: begin
          add_byte(sed_pkg::CHAR_BACKSLASH);
          add_byte(sed_pkg::CHAR_X);
          add_byte(($urandom_range(0, 6) == 0) ? pick_non_hex() : pick_hex_digit());
          add_byte(($urandom_range(0, 4) == 0) ? pick_non_hex() : pick_hex_digit());
        end
      endcase
    end
    // cut the tail now and then so strings end inside escapes
    if ($urandom_range(0, 3) == 0 && text_bytes.size() > 1) begin
      cut = $urandom_range(1, (text_bytes.size() > 3) ? 3 : text_bytes.size() - 1);
      repeat (cut) void'(text_bytes.pop_back());
    end
  endtask

  initial begin
    int guard;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed strings
    text_bytes = '{8'h00};
    send_text();
    text_bytes = '{sed_pkg::CHAR_BACKSLASH, sed_pkg::CHAR_N, sed_pkg::CHAR_BACKSLASH,
                   sed_pkg::CHAR_BACKSLASH, sed_pkg::CHAR_BACKSLASH, sed_pkg::CHAR_QUOTE,
                   8'hFF};
    send_text();
    // unknown escape ending the string
    text_bytes = '{sed_pkg::CHAR_BACKSLASH, 8'h51};
    send_text();
    // lone backslash at the end
    text_bytes = '{sed_pkg::CHAR_BACKSLASH};
    send_text();
    // hex escapes cut short by the end of the string
    text_bytes = '{sed_pkg::CHAR_BACKSLASH, sed_pkg::CHAR_X};
    send_text();
    text_bytes = '{sed_pkg::CHAR_BACKSLASH, sed_pkg::CHAR_X, 8'h34};
    send_text();
    // valid hex, then invalid first digit, then non-hex second digit
    text_bytes = '{sed_pkg::CHAR_BACKSLASH, sed_pkg::CHAR_X, 8'h34, 8'h46};
    send_text();
    text_bytes = '{sed_pkg::CHAR_BACKSLASH, sed_pkg::CHAR_X, 8'h67, 8'h31,
                   sed_pkg::CHAR_BACKSLASH, sed_pkg::CHAR_X, 8'h2B, 8'h31,
                   sed_pkg::CHAR_BACKSLASH, sed_pkg::CHAR_X, 8'h37, 8'h7A, 8'h6B};
    send_text();

    while (words_sent < RANDOM_WORDS) begin
      build_random_text();
      send_text();
    end
    in_valid <= 1'b0;

    guard = 0;
    while (expected_count != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (10) @(posedge clk);

    if (fail_count == 0 && expected_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/sed_pkg.sv
rtl/core/sed_front.sv
rtl/core/sed_queue.sv
rtl/core/sed_back.sv
rtl/core/string_escape_decoder_unit.sv
sim/string_escape_decoder_checker.sv
sim/string_escape_decoder_unit_test.sv
